[src/c8f_pkg.sv]
// Shared types and constants of the reduced CHIP-8 frame core.
package c8f_pkg;

	localparam int MEM_BYTES     = 4096;
	localparam int ROM_MAX_BYTES = 3584;
	localparam int SCREEN_WIDTH  = 64;
	localparam int SCREEN_HEIGHT = 32;

	localparam logic [11:0] ENTRY_ADDR    = 12'h200;
	localparam logic [15:0] OP_CLS        = 16'h00E0;
	localparam logic [7:0]  OP_SET_DT     = 8'h15;
	localparam logic [15:0] CYCLES_PER_OP = 16'd10;
	localparam logic [15:0] CFG_RESET     = 16'd110;

	// Input selector codes
	localparam logic [1:0] FUNC_LOAD  = 2'd0;
	localparam logic [1:0] FUNC_FRAME = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	// Opcode groups (top nibble)
	localparam logic [3:0] GRP_SYS   = 4'h0;
	localparam logic [3:0] GRP_SET   = 4'h6;
	localparam logic [3:0] GRP_ADD   = 4'h7;
	localparam logic [3:0] GRP_INDEX = 4'hA;
	localparam logic [3:0] GRP_DRAW  = 4'hD;
	localparam logic [3:0] GRP_MISC  = 4'hF;

	typedef enum logic [11:0] {
		ST_CLEAR    = 12'b0000_0000_0001,
		ST_IDLE     = 12'b0000_0000_0010,
		ST_LOOP     = 12'b0000_0000_0100,
		ST_FETCH_HI = 12'b0000_0000_1000,
		ST_FETCH_LO = 12'b0000_0001_0000,
		ST_EXEC     = 12'b0000_0010_0000,
		ST_CLS      = 12'b0000_0100_0000,
		ST_DRAW_Y   = 12'b0000_1000_0000,
		ST_DRAW_RD  = 12'b0001_0000_0000,
		ST_DRAW_WR  = 12'b0010_0000_0000,
		ST_PIX      = 12'b0100_0000_0000,
		ST_RESP     = 12'b1000_0000_0000
	} state_t;

endpackage

[src/c8f_ram.sv]
// Generic simple dual-port RAM with registered read.
module c8f_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word, read one word per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[src/chip8_subset_frame_core.sv]
// Top level of the reduced CHIP-8 frame core: sequencer, registers and memories.
// After reset the core sweeps main memory to zero (screen cleared alongside) and
// accepts no word meanwhile. A load or unused word goes straight to the response
// step, a read first samples one screen pixel. A frame runs budget/10 instructions,
// rounded down, plus a row-by-row sweep per screen clear and a read and a write step
// per sprite row drawn; every step goes through the one read port of main memory and
// of the 32 x 64-bit screen RAM, one access per cycle, and the budget is counted
// down by ten per instruction through one subtractor. The result sits in its own
// output register, so a new word is taken while it waits; the sequencer only holds
// in its last step when the previous result has still not been taken.
module chip8_subset_frame_core
	import c8f_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,    // frame budget, ten units per instruction
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,     // rom_offset[11:0], rom_byte[19:12], pixel_x[25:20],
	                                 // pixel_y[30:26], zero[31]
	input  logic [1:0]  s_tuser,     // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata      // status[0], pixel_value[1], delay_timer[9:2],
	                                 // frames_done[41:10], zero[47:42]
);

	state_t      state_q;
	logic [11:0] clr_q;
	logic [15:0] cycles_q;
	logic [15:0] budget_q;
	logic [11:0] pc_q;
	logic [11:0] index_q;
	logic [7:0]  delay_q;
	logic [31:0] frames_q;
	logic [7:0]  regs_q [16];
	logic [7:0]  op_hi_q;
	logic [7:0]  op_lo_q;
	logic [5:0]  px0_q;
	logic [4:0]  py0_q;
	logic [3:0]  row_q;
	logic [5:0]  pix_x_q;
	logic        status_q;
	logic        pixel_q;
	logic        m_tvalid_q;
	logic [47:0] m_data_q;

	logic [1:0]  in_func;
	logic [11:0] in_offset;
	logic [7:0]  in_byte;
	logic [5:0]  in_px;
	logic [4:0]  in_py;
	logic        s_accept;
	logic        resp_load;
	logic [15:0] op;
	logic [7:0]  reg_rd;
	logic [5:0]  ypos;
	logic [63:0] sprite_mask;
	logic [7:0]  bits_rev;
	logic        collide;

	logic        mem_we;
	logic [11:0] mem_waddr;
	logic [7:0]  mem_wdata;
	logic [11:0] mem_raddr;
	logic [7:0]  mem_rdata;
	logic        scr_we;
	logic [4:0]  scr_waddr;
	logic [63:0] scr_wdata;
	logic [4:0]  scr_raddr;
	logic [63:0] scr_rdata;

	assign in_func   = s_tuser;
	assign in_offset = s_tdata[11:0];
	assign in_byte   = s_tdata[19:12];
	assign in_px     = s_tdata[25:20];
	assign in_py     = s_tdata[30:26];

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign resp_load = (state_q == ST_RESP) && (!m_tvalid_q || m_tready);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_data_q;

	assign op     = {op_hi_q, op_lo_q};
	assign reg_rd = (state_q == ST_DRAW_Y) ? regs_q[op[7:4]] : regs_q[op[11:8]];
	assign ypos   = {1'b0, py0_q} + {2'b00, row_q};

	// Mirror the sprite byte so its bit 7 lands on column px0 and bit b on px0 + 7 - b
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			bits_rev[b] = mem_rdata[7-b];
		end
	end
	assign sprite_mask = {56'd0, bits_rev} << px0_q;
	assign collide     = |(scr_rdata & sprite_mask);

	// Main memory port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = 8'd0;
		mem_raddr = pc_q;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (s_accept && in_func == FUNC_LOAD &&
				in_offset < 12'(ROM_MAX_BYTES)) begin
			mem_we    = 1'b1;
			mem_waddr = ENTRY_ADDR + in_offset;
			mem_wdata = in_byte;
		end
		case (state_q)
			ST_FETCH_HI: mem_raddr = pc_q + 12'd1;
			ST_DRAW_RD:  mem_raddr = index_q + {8'd0, row_q};
			default:     mem_raddr = pc_q;
		endcase
	end

	// Screen RAM port selection
	always_comb begin
		scr_we    = 1'b0;
		scr_waddr = clr_q[4:0];
		scr_wdata = '0;
		case (state_q)
			ST_CLEAR, ST_CLS: scr_we = 1'b1;
			ST_DRAW_WR: begin
				scr_we    = !ypos[5];
				scr_waddr = ypos[4:0];
				scr_wdata = scr_rdata ^ sprite_mask;
			end
			default: scr_we = 1'b0;
		endcase
		scr_raddr = (state_q == ST_IDLE) ? in_py : ypos[4:0];
	end

	c8f_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	c8f_ram #(.WIDTH(SCREEN_WIDTH), .DEPTH(SCREEN_HEIGHT)) u_scr (
		.clk   (clk),
		.we    (scr_we),
		.waddr (scr_waddr),
		.wdata (scr_wdata),
		.raddr (scr_raddr),
		.rdata (scr_rdata)
	);

	// Sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			cycles_q   <= CFG_RESET;
			budget_q   <= '0;
			pc_q       <= ENTRY_ADDR;
			index_q    <= '0;
			delay_q    <= '0;
			frames_q   <= '0;
			m_tvalid_q <= 1'b0;
			m_data_q   <= '0;
			status_q   <= 1'b0;
			pixel_q    <= 1'b0;
			row_q      <= '0;
			op_hi_q    <= '0;
			op_lo_q    <= '0;
			px0_q      <= '0;
			py0_q      <= '0;
			pix_x_q    <= '0;
			for (int i = 0; i < 16; i++) begin
				regs_q[i] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				cycles_q <= cfg_data;
			end
			// Raise valid on a new result, drop it once taken
			if (resp_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 12'd1;
					if (clr_q == 12'(MEM_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_accept) begin
						status_q <= (in_func == FUNC_LOAD) &&
							!(in_offset < 12'(ROM_MAX_BYTES));
						pixel_q  <= 1'b0;
						pix_x_q  <= in_px;
						case (in_func)
							FUNC_LOAD: begin
								if (in_offset < 12'(ROM_MAX_BYTES)) begin
									pc_q <= ENTRY_ADDR;
								end
								state_q <= ST_RESP;
							end
							FUNC_FRAME: begin
								if (delay_q != 8'd0) begin
									delay_q <= delay_q - 8'd1;
								end
								budget_q <= cycles_q;
								state_q  <= ST_LOOP;
							end
							FUNC_READ: state_q <= ST_PIX;
							default:   state_q <= ST_RESP;
						endcase
					end
				end
				ST_LOOP: begin
					// Spend ten units of budget per instruction
					if (budget_q < CYCLES_PER_OP) begin
						frames_q <= frames_q + 32'd1;
						state_q  <= ST_RESP;
					end else begin
						budget_q <= budget_q - CYCLES_PER_OP;
						state_q  <= ST_FETCH_HI;
					end
				end
				ST_FETCH_HI: begin
					op_hi_q <= mem_rdata;
					state_q <= ST_FETCH_LO;
				end
				ST_FETCH_LO: begin
					op_lo_q <= mem_rdata;
					pc_q    <= pc_q + 12'd2;
					state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					case (op[15:12])
						GRP_SYS: begin
							clr_q   <= '0;
							state_q <= (op == OP_CLS) ? ST_CLS : ST_LOOP;
						end
						GRP_SET: begin
							regs_q[op[11:8]] <= op[7:0];
							state_q          <= ST_LOOP;
						end
						GRP_ADD: begin
							regs_q[op[11:8]] <= reg_rd + op[7:0];
							state_q          <= ST_LOOP;
						end
						GRP_INDEX: begin
							index_q <= op[11:0];
							state_q <= ST_LOOP;
						end
						GRP_DRAW: begin
							px0_q   <= reg_rd[5:0];
							state_q <= ST_DRAW_Y;
						end
						GRP_MISC: begin
							if (op[7:0] == OP_SET_DT) begin
								delay_q <= reg_rd;
							end
							state_q <= ST_LOOP;
						end
						default: state_q <= ST_LOOP;
					endcase
				end
				ST_CLS: begin
					clr_q <= clr_q + 12'd1;
					if (clr_q[4:0] == 5'(SCREEN_HEIGHT - 1)) begin
						state_q <= ST_LOOP;
					end
				end
				ST_DRAW_Y: begin
					py0_q      <= reg_rd[4:0];
					regs_q[15] <= 8'd0;
					row_q      <= '0;
					state_q    <= ST_DRAW_RD;
				end
				ST_DRAW_RD: begin
					state_q <= (row_q == op[3:0]) ? ST_LOOP : ST_DRAW_WR;
				end
				ST_DRAW_WR: begin
					// XOR one sprite row into the screen, flag any erased pixel
					if (!ypos[5] && collide) begin
						regs_q[15] <= 8'd1;
					end
					row_q   <= row_q + 4'd1;
					state_q <= ST_DRAW_RD;
				end
				ST_PIX: begin
					pixel_q <= scr_rdata[pix_x_q];
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					// Hold until the output register is free
					if (resp_load) begin
						m_data_q <= {6'd0, frames_q, delay_q, pixel_q, status_q};
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// Hold a waiting result unchanged
	a_resp_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while waiting");

	// One word at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> !s_tready) else $error("ready right after accept");

	// Frame count only steps by one
	a_frames_step: assert property (@(posedge clk) disable iff (!arst_n)
		(frames_q != $past(frames_q)) |-> (frames_q == $past(frames_q) + 32'd1))
		else $error("frame count jumped");
`endif

endmodule
